// ===== rtl/core/prt_pkg.sv =====
`timescale 1ns / 1ps
package prt_pkg;

  localparam int unsigned UserW  = 16;
  localparam int unsigned PageW  = 10;
  localparam int unsigned CountW = 17;
  localparam int unsigned FracW  = 17;
  localparam int unsigned UserSlots = 1 << UserW;
  localparam int unsigned PageSlots = 1 << PageW;
  localparam logic [FracW-1:0] OneQ16 = FracW'(65536);

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    cmd_e             cmd;
    logic [UserW-1:0] user_id;
    logic [PageW-1:0] page;
  } item_t;

endpackage

// ===== rtl/core/prt_fifo.sv =====
`timescale 1ns / 1ps
module prt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  prt_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output prt_pkg::item_t pop_data_o,
  output logic           empty_o
);

  prt_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/prt_div.sv =====
`timescale 1ns / 1ps
module prt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [prt_pkg::CountW-1:0]  lower_i,
  input  logic [prt_pkg::CountW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [prt_pkg::FracW-1:0]   frac_o
);

  localparam int unsigned NumW = prt_pkg::CountW + 16;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]            num_q, num_d;
  logic [prt_pkg::CountW:0]   rem_q, rem_d;
  logic [prt_pkg::CountW-1:0] den_q, den_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [prt_pkg::CountW+1:0] trial;

  // Restoring division, one quotient bit a cycle; quotient builds in num_q.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NumW-1]} - {2'b00, den_q};
    if (start_i) begin
      num_d  = {lower_i, 16'd0};
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[prt_pkg::CountW+1]) begin
        rem_d = trial[prt_pkg::CountW:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[prt_pkg::CountW-1:0], num_q[NumW-1]};
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign frac_o = (num_q > NumW'(prt_pkg::OneQ16)) ? prt_pkg::OneQ16
                                                    : num_q[prt_pkg::FracW-1:0];

endmodule

// ===== rtl/core/prt_back.sv =====
`timescale 1ns / 1ps
module prt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  input  prt_pkg::item_t             item_i,
  output logic                       item_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [prt_pkg::FracW-1:0]  res_o
);

  localparam int unsigned UserW  = prt_pkg::UserW;
  localparam int unsigned PageW  = prt_pkg::PageW;
  localparam int unsigned CountW = prt_pkg::CountW;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_ULOOK  = 11'b000_0000_0100,
    ST_UDEC   = 11'b000_0000_1000,
    ST_SWEEP  = 11'b000_0001_0000,
    ST_QLOOK  = 11'b000_0010_0000,
    ST_CREAD  = 11'b000_0100_0000,
    ST_CWAIT  = 11'b000_1000_0000,
    ST_DIV    = 11'b001_0000_0000,
    ST_OUT    = 11'b010_0000_0000,
    ST_SWAIT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // User table: bit PageW is the seen flag. Cleared by a sweep after reset.
  logic [PageW:0]  user_mem [prt_pkg::UserSlots];
  logic [PageW:0]  user_rd_q;
  logic            user_we;
  logic [UserW-1:0] user_wa;
  logic [PageW:0]  user_wd;

  logic [CountW-1:0] cnt_mem [prt_pkg::PageSlots];
  logic [CountW-1:0] cnt_rd_q;
  logic              cnt_we;
  logic [PageW-1:0]  cnt_wa, cnt_ra;
  logic [CountW-1:0] cnt_wd;

  logic [UserW:0]    clr_q, clr_d;
  prt_pkg::item_t    cur_q, cur_d;
  logic [CountW-1:0] active_q, active_d;
  logic [PageW:0]    idx_q, idx_d;       // sweep read index, one beyond at the end
  logic [CountW-1:0] delta_q, delta_d;
  logic              wb_q, wb_d;         // read data of previous index in flight
  logic [PageW-1:0]  wb_idx_q, wb_idx_d;
  logic [prt_pkg::FracW-1:0] res_q, res_d;
  logic              div_start;
  logic              div_done;
  logic [prt_pkg::FracW-1:0] div_frac;

  prt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .lower_i   (cnt_rd_q),
    .divisor_i (active_q - 1'b1),
    .done_o    (div_done),
    .frac_o    (div_frac)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    active_d  = active_q;
    idx_d     = idx_q;
    delta_d   = delta_q;
    wb_d      = 1'b0;
    wb_idx_d  = wb_idx_q;
    res_d     = res_q;
    item_pop_o = 1'b0;
    user_we   = 1'b0;
    user_wa   = cur_q.user_id;
    user_wd   = {1'b1, cur_q.page};
    cnt_we    = 1'b0;
    cnt_wa    = wb_idx_q;
    cnt_wd    = cnt_rd_q + delta_q;
    cnt_ra    = idx_q[PageW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        user_we = 1'b1;
        user_wa = clr_q[UserW-1:0];
        user_wd = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q[UserW-1:0] == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          state_d    = (item_i.cmd == prt_pkg::CMD_QUERY) ? ST_QLOOK : ST_ULOOK;
        end
      end
      ST_ULOOK: begin
        // user_rd_q holds the previous entry of this user.
        if (user_rd_q[PageW]) begin
          delta_d = '1;
          idx_d   = {1'b0, user_rd_q[PageW-1:0]};
          state_d = ST_SWEEP;
        end else begin
          active_d = active_q + 1'b1;
          state_d  = ST_UDEC;
        end
        user_we = 1'b1;
      end
      ST_UDEC: begin
        delta_d = CountW'(1);
        idx_d   = {1'b0, cur_q.page};
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        // Read one entry a cycle, write back the previous one plus delta.
        cnt_we = wb_q;
        if (!idx_q[PageW]) begin
          wb_d     = 1'b1;
          wb_idx_d = idx_q[PageW-1:0];
          idx_d    = idx_q + 1'b1;
        end else if (!wb_q) begin
          if (delta_q == '1) begin
            delta_d = CountW'(1);
            idx_d   = {1'b0, cur_q.page};
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_QLOOK: begin
        if (!user_rd_q[PageW]) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else if (active_q <= CountW'(1)) begin
          res_d   = prt_pkg::OneQ16;
          state_d = ST_OUT;
        end else if (user_rd_q[PageW-1:0] == '0) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else begin
          // The count just below the user's page stays addressed until the
          // divider has taken it.
          cnt_ra  = user_rd_q[PageW-1:0] - 1'b1;
          idx_d   = {1'b0, user_rd_q[PageW-1:0] - 1'b1};
          state_d = ST_CREAD;
        end
      end
      ST_CREAD: begin
        state_d = ST_CWAIT;
      end
      ST_CWAIT: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_d   = div_frac;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_SWAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = state_q == ST_OUT;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      active_q <= '0;
      wb_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      active_q <= active_d;
      wb_q     <= wb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    delta_q  <= delta_d;
    wb_idx_q <= wb_idx_d;
    res_q    <= res_d;
  end

  // User memory: read address is the incoming item's user in IDLE.
  always_ff @(posedge clk_i) begin
    if (user_we) begin
      user_mem[user_wa] <= user_wd;
    end
    user_rd_q <= user_mem[item_i.user_id];
  end

  // Count table: cleared alongside the user table during the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_rd_q <= '0;
    end else begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end else if (state_q == ST_CLEAR) begin
      cnt_mem[clr_q[PageW-1:0]] <= '0;
    end
  end

endmodule

// ===== rtl/core/prt_front.sv =====
`timescale 1ns / 1ps
module prt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic [31:0]    s_data_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output prt_pkg::item_t q_data_o
);

  // Register stage: holds one classified item until the queue takes it.
  logic           hold_q, hold_d;
  prt_pkg::item_t item_q, item_d;

  assign s_ready_o = !hold_q || !q_full_i;
  assign q_push_o  = hold_q && !q_full_i;
  assign q_data_o  = item_q;

  always_comb begin
    hold_d = hold_q;
    item_d = item_q;
    if (q_push_o) begin
      hold_d = 1'b0;
    end
    if (s_valid_i && s_ready_o) begin
      hold_d       = 1'b1;
      item_d.cmd   = prt_pkg::cmd_e'(s_data_i[0]);
      item_d.user_id = s_data_i[16:1];
      item_d.page  = s_data_i[26:17];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ===== rtl/core/percentile_rank_tracker.sv =====
`timescale 1ns / 1ps
// A query result is offered once the divider is done, or without the divider for an unknown
// user, a sole user or page zero. In the back part a record sweeps the count table from its
// new page upwards, and for a known user first from its old page upwards.
// Throughput: one transaction at a time in the back part, set by the count-table sweep (one
// entry a cycle) and the 33-step divider; up to three transactions may queue in front of it.
// Reset: asynchronous, active low; then a pass clears both tables while it queues.
module percentile_rank_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // command [0], user_id [16:1], page [26:17]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // rank_fraction [16:0]
);

  prt_pkg::item_t fr_item, q_item;
  logic           fr_push, q_full, q_empty, q_pop;
  logic [prt_pkg::FracW-1:0] res;

  // The front part registers and classifies each transaction.
  prt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .q_full_i  (q_full),
    .q_push_o  (fr_push),
    .q_data_o  (fr_item)
  );

  // A two-entry queue decouples the front part from the back part.
  prt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_push),
    .push_data_i (fr_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_item),
    .empty_o     (q_empty)
  );

  // The back part owns the tables and the divider.
  prt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule

// ===== rtl/core/prt_checker.sv =====
`timescale 1ns / 1ps
module prt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A result stalled by the sink holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The integer part of the fraction never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:16] <= 8'd1)
    else $error("fraction out of range");

  // After a delivered result, tvalid drops before any further result is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result repeated");

endmodule

bind percentile_rank_tracker prt_checker u_prt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the percentile rank tracker. Record and query
// transactions go in on the slave stream. A model of the page table and the
// cumulative count table, kept inside this bench, predicts every rank
// fraction that a query should return. The checker compares each returned
// transaction with the oldest outstanding prediction.
module tb;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 6000000;
  // The slowest record sweeps the whole count table twice, one entry a cycle.
  localparam int unsigned DrainCycles = 2200;
  localparam int unsigned PoolSize = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  percentile_rank_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow of the block's state: bit 10 of each page entry marks a user who
  // has been recorded at least once.
  logic [10:0]                page_of_user [prt_pkg::UserSlots];
  logic [prt_pkg::CountW-1:0] users_at_or_below [prt_pkg::PageSlots];
  logic [prt_pkg::CountW-1:0] active_count;

  logic [prt_pkg::FracW-1:0] expected_fracs [$];
  logic [prt_pkg::UserW-1:0] user_pool [PoolSize];
  int unsigned      mismatches;
  int unsigned      sender_idle_pct;
  int unsigned      receiver_idle_pct;
  int unsigned      hold_left;
  longint unsigned  cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Adds delta to every cumulative count from the given page upwards, modulo
  // the counter width, as the block's sweep does.
  task automatic shift_counts(input logic [prt_pkg::PageW-1:0] from_page,
                              input logic [prt_pkg::CountW-1:0] delta);
    for (int p = from_page; p < prt_pkg::PageSlots; p++) begin
      users_at_or_below[p] = users_at_or_below[p] + delta;
    end
  endtask

  // Updates the shadow state for one accepted transaction and, for a query,
  // queues the rank fraction that the block must return.
  task automatic predict_rank(input prt_pkg::cmd_e cmd,
                              input logic [prt_pkg::UserW-1:0] uid,
                              input logic [prt_pkg::PageW-1:0] page);
    logic [10:0]               entry;
    longint unsigned           lower;
    longint unsigned           quot;
    logic [prt_pkg::FracW-1:0] frac;
    entry = page_of_user[uid];
    if (cmd == prt_pkg::CMD_RECORD) begin
      if (entry[10]) begin
        shift_counts(entry[9:0], '1);
      end else begin
        active_count = active_count + 1'b1;
      end
      shift_counts(page, prt_pkg::CountW'(1));
      page_of_user[uid] = {1'b1, page};
    end else begin
      if (!entry[10]) begin
        frac = '0;
      end else if (active_count <= 1) begin
        frac = prt_pkg::OneQ16;
      end else begin
        // Nobody stands below page zero.
        lower = (entry[9:0] == 0) ? 0 : users_at_or_below[entry[9:0] - 1];
        quot  = (lower << 16) / longint'(active_count - 1);
        frac  = (quot > 65536) ? prt_pkg::OneQ16 : prt_pkg::FracW'(quot);
      end
      expected_fracs = {expected_fracs, frac};
    end
  endtask

  // Offers one transaction, idling first at the current sender rate, and
  // returns once the block has accepted it. tvalid stays high on exit so that
  // back-to-back transactions need no second assignment in one time step.
  task automatic send_item(input prt_pkg::cmd_e cmd,
                           input logic [prt_pkg::UserW-1:0] uid,
                           input logic [prt_pkg::PageW-1:0] page);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, page, uid, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rank(cmd, uid, page);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_fracs.size() != 0) @(posedge clk_i);
  endtask

  // Every special case in turn: an unknown user, a lone user, page zero,
  // the page and user extremes, equal pages and a user moving page.
  task automatic test_directed();
    send_item(prt_pkg::CMD_QUERY,  16'd0,     10'd5);    // nobody active yet
    send_item(prt_pkg::CMD_RECORD, 16'd5,     10'd0);
    send_item(prt_pkg::CMD_QUERY,  16'd5,     10'd0);    // sole user reads as one
    send_item(prt_pkg::CMD_QUERY,  16'd6,     10'd0);    // unknown user
    send_item(prt_pkg::CMD_RECORD, 16'd65535, 10'd1023);
    send_item(prt_pkg::CMD_QUERY,  16'd65535, 10'd0);    // everyone else lower
    send_item(prt_pkg::CMD_QUERY,  16'd5,     10'd1023); // page zero, nobody lower
    send_item(prt_pkg::CMD_RECORD, 16'd0,     10'd512);
    send_item(prt_pkg::CMD_QUERY,  16'd0,     10'd0);
    send_item(prt_pkg::CMD_RECORD, 16'd5,     10'd1023); // moves up to the top page
    send_item(prt_pkg::CMD_QUERY,  16'd65535, 10'd0);    // shares the page, not lower
    send_item(prt_pkg::CMD_QUERY,  16'd0,     10'd0);
    send_item(prt_pkg::CMD_RECORD, 16'd65535, 10'd1);    // moves down
    send_item(prt_pkg::CMD_QUERY,  16'd5,     10'd0);
    send_item(prt_pkg::CMD_RECORD, 16'd0,     10'd512);  // same page again
    send_item(prt_pkg::CMD_QUERY,  16'd0,     10'd0);
    send_item(prt_pkg::CMD_RECORD, 16'hAAAA,  10'h2AA);
    send_item(prt_pkg::CMD_RECORD, 16'h5555,  10'h155);
    send_item(prt_pkg::CMD_QUERY,  16'hAAAA,  10'h3FF);
    send_item(prt_pkg::CMD_QUERY,  16'h5555,  10'h3FF);
    wait_drained();
  endtask

  // Mostly a small pool of users, so that queries find recorded pages and
  // records move users about; now and then any user at all.
  task automatic test_random(input int unsigned count, input int unsigned snd_pct,
                             input int unsigned rcv_pct);
    logic [prt_pkg::UserW-1:0] uid;
    prt_pkg::cmd_e             cmd;
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    repeat (count) begin
      uid = ($urandom_range(99) < 85) ? user_pool[$urandom_range(PoolSize - 1)]
                                      : prt_pkg::UserW'($urandom);
      cmd = prt_pkg::cmd_e'($urandom_range(1));
      send_item(cmd, uid, prt_pkg::PageW'($urandom));
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while queries keep coming, so
  // the block's queue fills and it must drop s_axis_tready.
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_left = 3000;
    repeat (10) begin
      send_item(prt_pkg::CMD_QUERY, user_pool[$urandom_range(PoolSize - 1)], '0);
    end
    wait_drained();
  endtask

  // Receiver side: tready follows the idle rate unless a hold is running.
  always @(posedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_fracs.size() == 0) begin
        $error("rank_fraction: no result expected, actual %0d", m_axis_tdata[16:0]);
        mismatches++;
      end else begin
        if (m_axis_tdata[16:0] !== expected_fracs[0]) begin
          $error("rank_fraction: expected %0d, actual %0d", expected_fracs[0],
                 m_axis_tdata[16:0]);
          mismatches++;
        end
        void'(expected_fracs.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatches        = 0;
    cycle_count       = 0;
    hold_left         = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    rst_ni            = 1'b0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    m_axis_tready     = 1'b0;
    for (int u = 0; u < prt_pkg::UserSlots; u++) page_of_user[u] = '0;
    for (int p = 0; p < prt_pkg::PageSlots; p++) users_at_or_below[p] = '0;
    active_count = '0;
    user_pool[0] = 16'd0;
    user_pool[1] = 16'd65535;
    for (int i = 2; i < PoolSize; i++) user_pool[i] = prt_pkg::UserW'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(180, 21, 57);
    test_backpressure();
    test_random(180, 57, 21);
    test_random(180, 0, 0);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_fracs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
